// File: rtl/core/ppte_pkg.sv
// ----------------------------------------------------------------------------
// ppte_pkg: shared types and constants
// Request/result structs and fixed widths of the trajectory evaluator.
// ----------------------------------------------------------------------------
package ppte_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned AccW     = 48;
  localparam int unsigned TimeW    = 24;
  localparam int unsigned CoeffW   = 32;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqEval = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         segment;
    logic [1:0]         axis;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic [23:0]        time_offset;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               saturated;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StFirst,
    StMul,
    StAdd,
    StAxisDone,
    StDone
  } state_e;

endpackage

// File: rtl/core/piecewise_poly_traj_eval.sv
// ----------------------------------------------------------------------------
// piecewise_poly_traj_eval: piecewise polynomial trajectory evaluator
// Horner evaluation of x, y and z over stored segment coefficients.
// ----------------------------------------------------------------------------
// Usage: hold start high with req_i until a cycle in which busy is low.
// A load transfer writes one coefficient into the coefficient ram when its
// address is in range; it gives no result. An evaluate transfer runs
// Horner's rule on the three axes in turn and ends with a one-cycle valid_o
// strobe carrying res_o. The multiply is bit-serial: acc times time shifts
// in one time bit per cycle in StMul, each Horner step ends in StAdd, and
// each axis adds a ram read (StRead), a first-coefficient step (StFirst)
// and a clamp step (StAxisDone). An evaluate uses n = 2 * derivative order
// coefficients per axis, clamped to 2..MaxCoeffs, keeps busy high until
// the result is registered and strobes valid_o in the cycle after the last
// busy cycle. A bad segment goes straight to StDone and strobes likewise.
// The receiver cannot stall: the strobe lasts exactly one cycle. Reset
// sets derivative order to 3 and idles the sequencer; the coefficient ram
// is not cleared and must be loaded before use. cfg_we_i may be used only
// while busy is low.
// ----------------------------------------------------------------------------
module piecewise_poly_traj_eval #(
  parameter int unsigned MaxSegments = 16,
  parameter int unsigned MaxCoeffs   = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ppte_pkg::req_t  req_i,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_wdata_i,
  output logic            valid_o,
  output ppte_pkg::res_t  res_o
);
  import ppte_pkg::*;

  localparam int unsigned Depth = MaxSegments * NumAxes * MaxCoeffs;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SlotW = $clog2(MaxCoeffs);
  localparam int unsigned BitW  = $clog2(TimeW + 1);
  localparam int unsigned PW    = AccW + TimeW + 1;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  state_e state_q, state_d;
  logic [2:0]             order_q;
  logic [3:0]             seg_q;
  logic [1:0]             axis_q;
  logic [SlotW-1:0]       slot_q;
  logic [3:0]             ncoef_q;
  logic [TimeW-1:0]       time_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [PW-1:0]   prod_q;
  logic [TimeW-1:0]       tsh_q;
  logic [BitW-1:0]        bit_q;
  logic                   sat_q;
  logic signed [31:0]     px_q, py_q;
  logic                   valid_q;
  res_t                   res_q;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_addr;
  logic [CoeffW-1:0]      ram_rdata;
  logic                   load_ok;
  logic [4:0]             n_full;
  logic [3:0]             n_eff;

  assign busy = (state_q != StIdle);
  wire accept = start && !busy;

  // clamp 2*order into 2..MaxCoeffs
  assign n_full = {1'b0, order_q, 1'b0};
  always_comb begin
    if (n_full < 5'd2) begin
      n_eff = 4'd2;
    end else if (n_full > 5'(MaxCoeffs)) begin
      n_eff = 4'(MaxCoeffs);
    end else begin
      n_eff = n_full[3:0];
    end
  end

  assign load_ok = ({28'd0, req_i.segment} < 32'(MaxSegments)) && (req_i.axis != 2'd3)
                && ({28'd0, req_i.coeff_index} < 32'(MaxCoeffs));

  always_comb begin
    ram_we = accept && (req_i.req_type == ReqLoad) && load_ok;
    if (ram_we) begin
      ram_addr = AddrW'((32'(req_i.segment) * NumAxes + 32'(req_i.axis)) * MaxCoeffs
                        + 32'(req_i.coeff_index));
    end else begin
      ram_addr = AddrW'((32'(seg_q) * NumAxes + 32'(axis_q)) * MaxCoeffs + 32'(slot_q));
    end
  end

  ppte_ram #(.Width(CoeffW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (req_i.coeff_value),
    .rdata_o (ram_rdata)
  );

  // floor(prod / 2^16) then add coefficient, saturate to 48 bits
  logic signed [PW-16-1:0] shifted;
  logic signed [PW-16:0]   sum;
  logic signed [AccW-1:0]  acc_sat;
  logic                    acc_ovf;
  assign shifted = prod_q[PW-1:16];
  assign sum     = {shifted[PW-17], shifted} + (PW-15)'(signed'(ram_rdata));
  always_comb begin
    acc_ovf = 1'b0;
    acc_sat = sum[AccW-1:0];
    if (sum > (PW-15)'(AccMax)) begin
      acc_sat = AccMax;
      acc_ovf = 1'b1;
    end else if (sum < (PW-15)'(AccMin)) begin
      acc_sat = AccMin;
      acc_ovf = 1'b1;
    end
  end

  // 48-bit result clamp to 32 bits
  logic signed [31:0] out_sat;
  logic               out_ovf;
  always_comb begin
    out_ovf = 1'b0;
    out_sat = acc_q[31:0];
    if (acc_q > 48'sh0000_7FFF_FFFF) begin
      out_sat = 32'sh7FFF_FFFF;
      out_ovf = 1'b1;
    end else if (acc_q < -48'sh0000_8000_0000) begin
      out_sat = -32'sh8000_0000;
      out_ovf = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && req_i.req_type == ReqEval) begin
          if ({28'd0, req_i.segment} < 32'(MaxSegments)) begin
            state_d = StRead;
          end else begin
            state_d = StDone;
          end
        end
      end
      StRead:     state_d = StFirst;
      StFirst:    state_d = (ncoef_q > 4'd1) ? StMul : StAxisDone;
      StMul:      state_d = (bit_q == BitW'(TimeW - 1)) ? StAdd : StMul;
      StAdd:      state_d = (5'(slot_q) + 5'd1 < {1'b0, ncoef_q}) ? StMul : StAxisDone;
      StAxisDone: state_d = (axis_q == 2'd2) ? StDone : StRead;
      StDone:     state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      order_q <= 3'd3;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == StDone);
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        seg_q   <= req_i.segment;
        time_q  <= req_i.time_offset;
        axis_q  <= 2'd0;
        slot_q  <= '0;
        ncoef_q <= n_eff;
        sat_q   <= 1'b0;
        px_q    <= '0;
        py_q    <= '0;
        acc_q   <= '0;
        if (accept && req_i.req_type == ReqEval
            && !({28'd0, req_i.segment} < 32'(MaxSegments))) begin
          seg_q <= '0;
        end
      end
      StRead: ;
      StFirst: begin
        acc_q  <= AccW'(signed'(ram_rdata));
        slot_q <= SlotW'(1);
        prod_q <= '0;
        tsh_q  <= time_q;
        bit_q  <= '0;
      end
      StMul: begin
        // shift-add, msb of time first
        prod_q <= (prod_q <<< 1)
                + (tsh_q[TimeW-1] ? PW'(acc_q) : PW'(0));
        tsh_q  <= tsh_q << 1;
        bit_q  <= bit_q + BitW'(1);
      end
      StAdd: begin
        acc_q  <= acc_sat;
        sat_q  <= sat_q | acc_ovf;
        slot_q <= slot_q + SlotW'(1);
        prod_q <= '0;
        tsh_q  <= time_q;
        bit_q  <= '0;
      end
      StAxisDone: begin
        sat_q  <= sat_q | out_ovf;
        slot_q <= '0;
        axis_q <= axis_q + 2'd1;
        if (axis_q == 2'd0) px_q <= out_sat;
        if (axis_q == 2'd1) py_q <= out_sat;
        acc_q  <= AccW'(signed'(out_sat));
      end
      StDone: begin
        res_q.pos_x     <= px_q;
        res_q.pos_y     <= py_q;
        res_q.pos_z     <= acc_q[31:0];
        res_q.saturated <= sat_q;
      end
      default: ;
    endcase
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // the ram address read in StMul must advance only in StAdd
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul |=> $stable(slot_q))
    else $error("slot changed during multiply");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> valid_o)
    else $error("missing result strobe");

endmodule

// File: rtl/core/ppte_ram.sv
// ----------------------------------------------------------------------------
// ppte_ram: generic single-port ram
// One read per cycle, plus a write to the same address when we_i is high; registered read data.
// ----------------------------------------------------------------------------
module ppte_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 576
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for piecewise_poly_traj_eval
// Loads coefficient sets and evaluates x/y/z positions over several derivative
// orders. Expected positions come from a bit-exact Horner model in the bench.
// ----------------------------------------------------------------------------
module tb;
  import ppte_pkg::*;

  localparam int unsigned NumSeg    = 16;
  localparam int unsigned NumSlot   = 12;
  localparam int unsigned CycLimit  = 4000000;
  localparam int unsigned SettleCyc = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;
  logic       valid_o;
  res_t       res_o;

  piecewise_poly_traj_eval dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o    (valid_o),
    .res_o      (res_o)
  );

  // bench copy of the coefficient ram and the order register
  logic signed [31:0] coeff_mem [NumSeg][NumAxes][NumSlot];
  logic [2:0]         order_reg;
  // generation-time record of which slots have been written
  bit                 loaded [NumSeg][NumAxes][NumSlot];
  int unsigned        gen_n;

  req_t        pending_reqs [$];
  res_t        expected_pos [$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned gap;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned coeff_count(logic [2:0] ord);
    int unsigned n;
    n = 2 * ord;
    if (n < 2) n = 2;
    if (n > NumSlot) n = NumSlot;
    return n;
  endfunction

  function automatic res_t predict_position(logic [3:0] seg, logic [23:0] t);
    res_t               r;
    logic signed [47:0] acc;
    logic signed [79:0] a80, t80, c80, sum;
    logic signed [31:0] axis_pos [NumAxes];
    int unsigned        n;
    n = coeff_count(order_reg);
    r = '0;
    t80 = {56'b0, t};
    for (int a = 0; a < NumAxes; a++) begin
      acc = 48'(coeff_mem[seg][a][0]);
      for (int i = 1; i < n; i++) begin
        a80 = 80'(acc);
        c80 = 80'(coeff_mem[seg][a][i]);
        sum = ((a80 * t80) >>> 16) + c80;
        if (sum > 80'sh7FFF_FFFF_FFFF) begin
          acc = 48'sh7FFF_FFFF_FFFF;
          r.saturated = 1'b1;
        end else if (sum < -80'sh8000_0000_0000) begin
          acc = 48'sh8000_0000_0000;
          r.saturated = 1'b1;
        end else begin
          acc = sum[47:0];
        end
      end
      if (acc > 48'sh0000_7FFF_FFFF) begin
        axis_pos[a] = 32'sh7FFF_FFFF;
        r.saturated = 1'b1;
      end else if (acc < -48'sh0000_8000_0000) begin
        axis_pos[a] = 32'sh8000_0000;
        r.saturated = 1'b1;
      end else begin
        axis_pos[a] = acc[31:0];
      end
    end
    r.pos_x = axis_pos[0];
    r.pos_y = axis_pos[1];
    r.pos_z = axis_pos[2];
    return r;
  endfunction

  // driver: one nonblocking write of start per edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
      gap = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        go = 1'b0;
        if (req_i.req_type == ReqLoad) begin
          if (req_i.axis < NumAxes && req_i.coeff_index < NumSlot)
            coeff_mem[req_i.segment][req_i.axis][req_i.coeff_index] = req_i.coeff_value;
        end else begin
          expected_pos = {expected_pos,
                          predict_position(req_i.segment, req_i.time_offset)};
        end
      end
      if (!go) begin
        if (gap > 0) begin
          gap = gap - 1;
        end else if (pending_reqs.size() > 0) begin
          req_i <= pending_reqs.pop_front();
          go = 1'b1;
          gap = 0;
          if (!no_idle) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: gap = 0;
              6, 7, 8:          gap = $urandom_range(1, 4);
              default:          gap = $urandom_range(10, 60);
            endcase
          end
        end
      end
      start <= go;
    end
  end

  // monitor: results cannot be held off, so check every strobe
  always @(posedge clk_i) begin
    res_t want;
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_ni && valid_o) begin
      if (expected_pos.size() == 0) begin
        $error("result with no evaluate outstanding");
        mismatches++;
      end else begin
        want = expected_pos.pop_front();
        if (res_o.pos_x !== want.pos_x) begin
          $error("pos_x expected %0d got %0d", want.pos_x, res_o.pos_x);
          mismatches++;
        end
        if (res_o.pos_y !== want.pos_y) begin
          $error("pos_y expected %0d got %0d", want.pos_y, res_o.pos_y);
          mismatches++;
        end
        if (res_o.pos_z !== want.pos_z) begin
          $error("pos_z expected %0d got %0d", want.pos_z, res_o.pos_z);
          mismatches++;
        end
        if (res_o.saturated !== want.saturated) begin
          $error("saturated expected %0b got %0b", want.saturated, res_o.saturated);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [23:0] rand_time();
    case ($urandom_range(0, 7))
      0:       return 24'h00_0000;
      1:       return 24'hFF_FFFF;
      2, 3:    return 24'($urandom);
      default: return 24'($urandom_range(0, 24'h02_0000));
    endcase
  endfunction

  task automatic add_load(int unsigned seg, int unsigned ax, int unsigned slot,
                          logic [31:0] val);
    req_t r;
    r = '0;
    r.time_offset = 24'($urandom);
    r.req_type    = ReqLoad;
    r.segment     = 4'(seg);
    r.axis        = 2'(ax);
    r.coeff_index = 4'(slot);
    r.coeff_value = val;
    if (ax < NumAxes && slot < NumSlot) loaded[seg][ax][slot] = 1'b1;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic add_eval(int unsigned seg, logic [23:0] t);
    req_t r;
    r = '0;
    r.axis        = 2'($urandom);
    r.coeff_index = 4'($urandom);
    r.coeff_value = $urandom;
    r.req_type    = ReqEval;
    r.segment     = 4'(seg);
    r.time_offset = t;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic bit seg_ready(int unsigned seg);
    for (int a = 0; a < NumAxes; a++)
      for (int i = 0; i < gen_n; i++)
        if (!loaded[seg][a][i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_segment(int unsigned seg, logic [31:0] val, bit rnd);
    for (int a = 0; a < NumAxes; a++)
      for (int i = 0; i < gen_n; i++)
        add_load(seg, a, i, rnd ? rand_coeff() : val);
  endtask

  // block must be idle before a register write
  task automatic drain();
    wait (pending_reqs.size() == 0 && !start && expected_pos.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
    wait (!busy);
  endtask

  task automatic write_order(logic [2:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    order_reg = v;
    cfg_we_i <= 1'b0;
    gen_n = coeff_count(v);
  endtask

  task automatic random_phase(logic [2:0] ord, int unsigned budget);
    int unsigned seg;
    int unsigned base;
    write_order(ord);
    no_idle = ($urandom_range(0, 3) == 0);
    base = pending_reqs.size();
    while (pending_reqs.size() - base < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          seg = $urandom_range(0, NumSeg - 1);
          load_segment(seg, '0, 1'b1);
          repeat ($urandom_range(1, 3)) add_eval(seg, rand_time());
        end
        6, 7: begin
          seg = $urandom_range(0, NumSeg - 1);
          if (seg_ready(seg)) add_eval(seg, rand_time());
        end
        default: begin
          // stray loads: random slots, including unused ones, and out-of-range addresses
          add_load($urandom_range(0, NumSeg - 1), $urandom_range(0, 3),
                   $urandom_range(0, 15), $urandom);
        end
      endcase
    end
  endtask

  initial begin
    logic [2:0] orders [8];
    orders      = '{3'd3, 3'd6, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4, 3'd1};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    mismatches  = 0;
    cycles      = 0;
    no_idle     = 1'b0;
    order_reg   = 3'd3;
    gen_n       = coeff_count(3'd3);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes at the shortest polynomial
    write_order(3'd1);
    load_segment(0, 32'h7FFF_FFFF, 1'b0);
    add_eval(0, 24'hFF_FFFF);
    add_eval(0, 24'h00_0000);
    load_segment(15, 32'h8000_0000, 1'b0);
    add_eval(15, 24'hFF_FFFF);
    // bad-address loads and a valid load to segment 15 must leave segment 0 untouched
    add_load(0, 3, 0, 32'h0000_0000);
    add_load(0, 0, 15, 32'h0000_0000);
    add_load(15, 2, 11, 32'h0001_0000);
    add_eval(0, 24'h01_8000);

    foreach (orders[k]) random_phase(orders[k], 90);

    drain();
    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
